@@ design/dgt_pkg.sv @@
`timescale 1ns / 1ps

package dgt_pkg;

	// Field widths
	localparam int COORD_W = 24;
	localparam int IDX_W   = 20;
	localparam int FACE_W  = 21;
	localparam int DIM_W   = 11;
	localparam int LIM_W   = 23;
	localparam int CFG_W   = 23;
	localparam int REG_W   = 2;

	// Register indexes
	localparam logic [REG_W-1:0] REG_ROW_WIDTH  = 2'd0;
	localparam logic [REG_W-1:0] REG_ROW_COUNT  = 2'd1;
	localparam logic [REG_W-1:0] REG_EDGE_LIMIT = 2'd2;

	// Register reset values and the smallest usable grid dimension
	localparam logic [DIM_W-1:0] ROW_WIDTH_RST  = 11'd640;
	localparam logic [DIM_W-1:0] ROW_COUNT_RST  = 11'd480;
	localparam logic [LIM_W-1:0] EDGE_LIMIT_RST = 23'd655;
	localparam int               DIM_MIN        = 2;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic                      point_valid;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]  corner_a;
		logic [IDX_W-1:0]  corner_b;
		logic [IDX_W-1:0]  corner_c;
		logic [FACE_W-1:0] face_count;
		logic              last_of_run;
	} out_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic                      valid;
	} vtx_t;

endpackage

@@ design/depth_grid_triangulator_unit.sv @@
`timescale 1ns / 1ps

// Channel  Dir  Handshake          Payload
// in       in   in_valid/in_stall  in_item  (in_item_t: one vertex)
// out      out  out_valid/out_stall out_item (out_item_t: one triangle)
// cfg      in   cfg_we             cfg_index, cfg_data
//
// A vertex enters every cycle when it completes at most one triangle and the output does
// not stall; a vertex that completes two triangles holds the input while its second triangle waits.
// From the accepting edge of a vertex, its first triangle passes the line-store read,
// difference, square, sum/compare and output registers in that order before out_valid
// rises with it.
// Reset clears counters, neighbor registers and pipeline valids; the line store is
// not cleared and is written before it is read in a normal frame.
// A stalled output register backs up the pipeline, which then stalls the input.

module depth_grid_triangulator_unit
	import dgt_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_item_t           in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output out_item_t          out_item,
	input  logic               cfg_we,
	input  logic [REG_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]   cfg_data
);

	localparam int CW    = (MAX_WIDTH  > 2) ? $clog2(MAX_WIDTH)  : 1;
	localparam int RW    = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int PW    = RW + WW;
	localparam int DW    = COORD_W + 1;
	localparam int PRD_W = 2 * DW;
	localparam int SQ_W  = 2 * COORD_W + 1;
	localparam int SUM_W = SQ_W + 2;
	localparam int LSQ_W = 2 * LIM_W;
	localparam int NE    = 4;

	// Configuration registers
	logic [DIM_W-1:0] row_width_q;
	logic [DIM_W-1:0] row_count_q;
	logic [LIM_W-1:0] edge_limit_q;
	logic [LSQ_W-1:0] lim_sq_q;

	// Raster counters and neighbor registers
	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	vtx_t              left_q;
	vtx_t              ul_q;
	logic [FACE_W-1:0] faces_q;

	// Line store
	vtx_t line_mem [MAX_WIDTH];

	// Stage 1: read data and current vertex
	logic          valid_s1;
	vtx_t          cur_s1;
	vtx_t          up_s1;
	logic [CW-1:0] col_s1;
	logic [RW-1:0] row_s1;
	logic          fend_s1;

	// Stage 2: coordinate differences and row base
	logic                 valid_s2;
	logic signed [DW-1:0] d_s2 [NE][3];
	logic [1:0]           vflag_s2;
	logic                 cell_s2;
	logic                 fend_s2;
	logic [PW-1:0]        rw_s2;
	logic [CW-1:0]        col_s2;

	// Stage 3: squared components and corner index
	logic             valid_s3;
	logic [SQ_W-1:0]  sq_s3 [NE][3];
	logic [1:0]       vflag_s3;
	logic             cell_s3;
	logic             fend_s3;
	logic [IDX_W-1:0] idx3_s3;

	// Stage 4: pending triangles
	logic             valid_s4;
	logic [1:0]       mask_s4;
	logic             fend_s4;
	logic [IDX_W-1:0] i0_s4;
	logic [IDX_W-1:0] i1_s4;
	logic [IDX_W-1:0] i2_s4;
	logic [IDX_W-1:0] i3_s4;

	// Output register
	logic      out_valid_q;
	out_item_t out_item_q;

	logic [WW-1:0]        w_eff;
	logic [HW-1:0]        h_eff;
	logic                 acc;
	logic                 adv;
	logic                 col_last;
	logic                 row_last;
	vtx_t                 cur_in;
	logic signed [DW-1:0] d_c [NE][3];
	logic signed [PRD_W-1:0] prd_c [NE][3];
	logic [SUM_W-1:0]     sum_c [NE];
	logic [NE-1:0]        short_c;
	logic [1:0]           ok_c;
	logic                 out_free;
	logic                 emit_now;
	logic [1:0]           rem;
	logic                 done;

	function automatic logic signed [DW-1:0] coord_diff(
		logic signed [COORD_W-1:0] a,
		logic signed [COORD_W-1:0] b
	);
		return DW'(a) - DW'(b);
	endfunction

	// Clamp grid dimensions to the supported range
	always_comb begin
		if (row_width_q < DIM_W'(DIM_MIN)) begin
			w_eff = WW'(DIM_MIN);
		end else if (32'(row_width_q) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(row_width_q);
		end
		if (row_count_q < DIM_W'(DIM_MIN)) begin
			h_eff = HW'(DIM_MIN);
		end else if (32'(row_count_q) > 32'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(row_count_q);
		end
	end

	assign col_last = (32'(col_q) + 32'd1) >= 32'(w_eff);
	assign row_last = (32'(row_q) + 32'd1) >= 32'(h_eff);

	assign cur_in = '{x: in_item.pos_x, y: in_item.pos_y, z: in_item.pos_z,
		valid: in_item.point_valid};

	// Drain pending triangles into the output register
	assign out_free = !out_valid_q || !out_stall;
	assign emit_now = valid_s4 && (mask_s4 != 2'b00);
	assign rem      = mask_s4[0] ? {mask_s4[1], 1'b0} : 2'b00;
	assign done     = valid_s4 && ((mask_s4 == 2'b00) || (out_free && (rem == 2'b00)));
	assign adv      = !valid_s4 || done;
	assign in_stall = !adv;
	assign acc      = in_valid && adv;

	// Write configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q  <= ROW_WIDTH_RST;
			row_count_q  <= ROW_COUNT_RST;
			edge_limit_q <= EDGE_LIMIT_RST;
			lim_sq_q     <= '0;
		end else begin
			lim_sq_q <= LSQ_W'(edge_limit_q) * LSQ_W'(edge_limit_q);
			if (cfg_we) begin
				case (cfg_index)
					REG_ROW_WIDTH:  row_width_q  <= cfg_data[DIM_W-1:0];
					REG_ROW_COUNT:  row_count_q  <= cfg_data[DIM_W-1:0];
					REG_EDGE_LIMIT: edge_limit_q <= cfg_data[LIM_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Read old entry and write the new vertex at the same column
	always_ff @(posedge clk) begin
		if (acc) begin
			line_mem[col_q] <= cur_in;
			up_s1           <= line_mem[col_q];
		end
	end

	// Advance raster counters and neighbor registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			left_q <= '0;
			ul_q   <= '0;
		end else begin
			if (acc) begin
				if (col_last) begin
					col_q <= '0;
					row_q <= row_last ? '0 : RW'(32'(row_q) + 32'd1);
				end else begin
					col_q <= CW'(32'(col_q) + 32'd1);
				end
			end
			if (adv && valid_s1) begin
				left_q <= cur_s1;
				ul_q   <= up_s1;
			end
		end
	end

	// Form edge differences for both triangles
	always_comb begin
		d_c[0][0] = coord_diff(up_s1.x, ul_q.x);
		d_c[0][1] = coord_diff(up_s1.y, ul_q.y);
		d_c[0][2] = coord_diff(up_s1.z, ul_q.z);
		d_c[1][0] = coord_diff(left_q.x, ul_q.x);
		d_c[1][1] = coord_diff(left_q.y, ul_q.y);
		d_c[1][2] = coord_diff(left_q.z, ul_q.z);
		d_c[2][0] = coord_diff(cur_s1.x, up_s1.x);
		d_c[2][1] = coord_diff(cur_s1.y, up_s1.y);
		d_c[2][2] = coord_diff(cur_s1.z, up_s1.z);
		d_c[3][0] = coord_diff(left_q.x, up_s1.x);
		d_c[3][1] = coord_diff(left_q.y, up_s1.y);
		d_c[3][2] = coord_diff(left_q.z, up_s1.z);
	end

	// Square each difference
	always_comb begin
		for (int e = 0; e < NE; e++) begin
			for (int k = 0; k < 3; k++) begin
				prd_c[e][k] = PRD_W'(d_s2[e][k]) * PRD_W'(d_s2[e][k]);
			end
		end
	end

	// Sum squares and compare against the squared limit
	always_comb begin
		for (int e = 0; e < NE; e++) begin
			sum_c[e]   = SUM_W'(sq_s3[e][0]) + SUM_W'(sq_s3[e][1]) + SUM_W'(sq_s3[e][2]);
			short_c[e] = sum_c[e] < SUM_W'(lim_sq_q);
		end
		ok_c[0] = vflag_s3[0] && short_c[0] && short_c[1];
		ok_c[1] = vflag_s3[1] && short_c[2] && short_c[3];
	end

	// Pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			mask_s4  <= 2'b00;
		end else if (adv) begin
			valid_s1 <= acc;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			mask_s4  <= (valid_s3 && cell_s3) ? ok_c : 2'b00;
		end else if (out_free && emit_now) begin
			mask_s4 <= rem;
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			if (acc) begin
				cur_s1  <= cur_in;
				col_s1  <= col_q;
				row_s1  <= row_q;
				fend_s1 <= col_last && row_last;
			end
			d_s2        <= d_c;
			vflag_s2[0] <= ul_q.valid && up_s1.valid && left_q.valid;
			vflag_s2[1] <= up_s1.valid && cur_s1.valid && left_q.valid;
			cell_s2     <= (row_s1 != '0) && (col_s1 != '0);
			fend_s2     <= fend_s1;
			rw_s2       <= PW'(row_s1) * PW'(w_eff);
			col_s2      <= col_s1;
			for (int e = 0; e < NE; e++) begin
				for (int k = 0; k < 3; k++) begin
					sq_s3[e][k] <= prd_c[e][k][SQ_W-1:0];
				end
			end
			vflag_s3 <= vflag_s2;
			cell_s3  <= cell_s2;
			fend_s3  <= fend_s2;
			idx3_s3  <= IDX_W'(rw_s2 + PW'(col_s2));
			fend_s4  <= fend_s3;
			i3_s4    <= idx3_s3;
			i2_s4    <= idx3_s3 - IDX_W'(1);
			i1_s4    <= idx3_s3 - IDX_W'(w_eff);
			i0_s4    <= idx3_s3 - IDX_W'(w_eff) - IDX_W'(1);
		end
	end

	// Load the output register and count faces
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			faces_q     <= '0;
		end else begin
			if (out_free) begin
				out_valid_q <= emit_now;
			end
			if (done && fend_s4) begin
				faces_q <= '0;
			end else if (out_free && emit_now) begin
				faces_q <= faces_q + FACE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit_now) begin
			out_item_q.corner_a    <= mask_s4[0] ? i0_s4 : i1_s4;
			out_item_q.corner_b    <= mask_s4[0] ? i1_s4 : i3_s4;
			out_item_q.corner_c    <= i2_s4;
			out_item_q.face_count  <= faces_q + FACE_W'(1);
			out_item_q.last_of_run <= (rem == 2'b00);
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// Two pending triangles always hold the input
	a_pair_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && (mask_s4 == 2'b11)) |-> in_stall)
		else $error("input taken while two triangles pending");

	// The second triangle of a vertex follows the first without a gap
	a_pair_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !out_item.last_of_run) |=> out_valid)
		else $error("gap inside a triangle pair");

	// Face count steps by one inside a pair
	a_pair_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !out_item.last_of_run) |=>
		(out_item.face_count == $past(out_item.face_count) + FACE_W'(1)))
		else $error("face count not consecutive inside a pair");

	// Read data holds while its vertex waits in stage 1
	a_read_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && in_stall) |=> (up_s1 === $past(up_s1)))
		else $error("line store read data lost under stall");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import dgt_pkg::*;

	localparam int LINE_DEPTH   = 1024;
	localparam int ROW_LIMIT    = 1024;
	localparam int IDLE_CYCLES  = 12;
	localparam int STALL_LIMIT  = 4000;
	localparam int RANDOM_ITEMS = 320;
	localparam int unsigned LIM_MAX = (1 << LIM_W) - 1;

	// Mirror of the triangulator: line store, neighbors, counters, and the
	// triangles still owed by the block, oldest first.
	class triangle_predictor;
		vtx_t              line_store[LINE_DEPTH];
		vtx_t              left_v;
		vtx_t              upleft_v;
		int unsigned       col;
		int unsigned       row;
		logic [FACE_W-1:0] faces;
		logic [DIM_W-1:0]  width_reg;
		logic [DIM_W-1:0]  count_reg;
		logic [LIM_W-1:0]  limit_reg;
		out_item_t         triangles_due[$];
		int                errors;
		int                reported;

		function new();
			left_v    = '0;
			upleft_v  = '0;
			col       = 0;
			row       = 0;
			faces     = '0;
			width_reg = ROW_WIDTH_RST;
			count_reg = ROW_COUNT_RST;
			limit_reg = EDGE_LIMIT_RST;
			errors    = 0;
			reported  = 0;
		endfunction

		function void write_reg(logic [REG_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_ROW_WIDTH: begin
					width_reg = data[DIM_W-1:0];
				end
				REG_ROW_COUNT: begin
					count_reg = data[DIM_W-1:0];
				end
				REG_EDGE_LIMIT: begin
					limit_reg = data[LIM_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		function int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned hi);
			int unsigned u;
			u = 32'(v);
			if (u < DIM_MIN)
				return DIM_MIN;
			if (u > hi)
				return hi;
			return u;
		endfunction

		// Exact squared length against squared limit, strict less-than
		function bit edge_short(vtx_t a, vtx_t b);
			longint          dx, dy, dz;
			longint unsigned sq, lim;
			dx  = longint'($signed(b.x)) - longint'($signed(a.x));
			dy  = longint'($signed(b.y)) - longint'($signed(a.y));
			dz  = longint'($signed(b.z)) - longint'($signed(a.z));
			sq  = dx * dx + dy * dy + dz * dz;
			lim = longint'(limit_reg) * longint'(limit_reg);
			return sq < lim;
		endfunction

		function bit face_ok(vtx_t p, vtx_t q, vtx_t r);
			return p.valid && q.valid && r.valid && edge_short(p, q) && edge_short(p, r);
		endfunction

		function void add_face(int unsigned a, int unsigned b, int unsigned c);
			out_item_t t;
			faces         = faces + FACE_W'(1);
			t.corner_a    = a[IDX_W-1:0];
			t.corner_b    = b[IDX_W-1:0];
			t.corner_c    = c[IDX_W-1:0];
			t.face_count  = faces;
			t.last_of_run = 1'b0;
			triangles_due.push_back(t);
		endfunction

		function void note_vertex(in_item_t it);
			vtx_t        cur, up;
			int unsigned w, h, c, r;
			int          n;
			w         = clamp_dim(width_reg, LINE_DEPTH);
			h         = clamp_dim(count_reg, ROW_LIMIT);
			c         = col % LINE_DEPTH;
			r         = row;
			n         = 0;
			cur.x     = it.pos_x;
			cur.y     = it.pos_y;
			cur.z     = it.pos_z;
			cur.valid = it.point_valid;
			up        = line_store[c];

			// Lower-right corner of a cell: test both triangles
			if (r >= 1 && c >= 1) begin
				if (face_ok(upleft_v, up, left_v)) begin
					add_face((r - 1) * w + c - 1, (r - 1) * w + c, r * w + c - 1);
					n++;
				end
				if (face_ok(up, cur, left_v)) begin
					add_face((r - 1) * w + c, r * w + c, r * w + c - 1);
					n++;
				end
				if (n > 0)
					triangles_due[triangles_due.size() - 1].last_of_run = 1'b1;
			end

			// Shift neighbors and update the line store
			upleft_v      = up;
			line_store[c] = cur;
			left_v        = cur;

			// Advance raster position; wrap the frame and clear the face count
			if (c + 1 >= w) begin
				col = 0;
				if (r + 1 >= h) begin
					row   = 0;
					faces = '0;
				end else begin
					row = r + 1;
				end
			end else begin
				col = c + 1;
			end
		endfunction

		function void check_triangle(out_item_t got);
			out_item_t want;
			if (triangles_due.size() == 0) begin
				errors++;
				if (reported < 10)
					$display("unexpected triangle: a=%0d b=%0d c=%0d faces=%0d last=%0b",
						got.corner_a, got.corner_b, got.corner_c, got.face_count,
						got.last_of_run);
				reported++;
				return;
			end
			want = triangles_due.pop_front();
			if (got.corner_a !== want.corner_a || got.corner_b !== want.corner_b ||
					got.corner_c !== want.corner_c || got.face_count !== want.face_count ||
					got.last_of_run !== want.last_of_run) begin
				errors++;
				if (reported < 10)
					$display({"triangle mismatch at %0t: expected a=%0d b=%0d c=%0d ",
						"faces=%0d last=%0b, got a=%0d b=%0d c=%0d faces=%0d last=%0b"},
						$realtime, want.corner_a, want.corner_b, want.corner_c,
						want.face_count, want.last_of_run, got.corner_a, got.corner_b,
						got.corner_c, got.face_count, got.last_of_run);
				reported++;
			end
		endfunction

		function void close_out();
			if (triangles_due.size() != 0) begin
				errors += triangles_due.size();
				$display("%0d expected triangles never appeared", triangles_due.size());
			end
		endfunction
	endclass

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_stall;
	in_item_t         in_item   = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	out_item_t        out_item;
	logic             cfg_we    = 1'b0;
	logic [REG_W-1:0] cfg_index = REG_ROW_WIDTH;
	logic [CFG_W-1:0] cfg_data  = '0;

	triangle_predictor mesh;
	bit                steady;
	int                quiet_cycles = 0;
	int                stall_left   = 0;

	// Surface the grid vertices are drawn from
	int base_x, base_y, base_z;
	int pitch, jitter, depth_jitter;
	int valid_pct, noise_pct;

	always #10 clk = ~clk;

	depth_grid_triangulator_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	function automatic int pick_gap();
		int roll;
		if (steady)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic int jit(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic in_item_t vertex_at(int x, int y, int z, bit v);
		in_item_t it;
		it.pos_x       = x[COORD_W-1:0];
		it.pos_y       = y[COORD_W-1:0];
		it.pos_z       = z[COORD_W-1:0];
		it.point_valid = v;
		return it;
	endfunction

	// Mostly a jittered grid at the current raster position, some raw noise
	function automatic in_item_t grid_vertex();
		int       cx, ry;
		in_item_t it;
		cx = mesh.col;
		ry = mesh.row;
		if ($urandom_range(0, 99) < noise_pct) begin
			it.pos_x       = COORD_W'($urandom);
			it.pos_y       = COORD_W'($urandom);
			it.pos_z       = COORD_W'($urandom);
			it.point_valid = 1'($urandom_range(0, 1));
			return it;
		end
		return vertex_at(base_x + cx * pitch + jit(jitter), base_y + ry * pitch + jit(jitter),
			base_z + jit(depth_jitter), $urandom_range(0, 99) < valid_pct);
	endfunction

	// Check every accepted triangle; watch for a stalled run
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			mesh.check_triangle(out_item);
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("depth_grid_triangulator_unit test failed");
			$finish;
		end
	end

	// Random output backpressure, held off in steady stretches
	always @(negedge clk) begin
		int g;
		if (stall_left > 0) begin
			stall_left--;
		end else if (steady || out_stall) begin
			out_stall <= 1'b0;
			stall_left = steady ? 0 : $urandom_range(0, 6);
		end else begin
			g = pick_gap();
			out_stall <= (g != 0);
			stall_left = g;
		end
	end

	task automatic set_reg(logic [REG_W-1:0] idx, int unsigned data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(data);
		@(negedge clk);
		mesh.write_reg(idx, CFG_W'(data));
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Hold the vertex until taken, then maybe drop valid for a gap
	task automatic send_vertex(in_item_t it);
		int gap;
		in_item  <= it;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		mesh.note_vertex(it);
		@(negedge clk);
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Drain every owed triangle, then let vertices with no triangle clear the pipe
	task automatic settle();
		in_valid <= 1'b0;
		while (mesh.triangles_due.size() != 0)
			@(negedge clk);
		repeat (IDLE_CYCLES) @(negedge clk);
	endtask

	task automatic new_setting();
		int roll;
		settle();
		steady       = ($urandom_range(0, 99) < 20);
		pitch        = ($urandom_range(0, 99) < 85) ? $urandom_range(16, 3000)
			: $urandom_range(100000, 2000000);
		jitter       = pitch / $urandom_range(3, 12);
		depth_jitter = $urandom_range(0, pitch);
		base_x       = jit(8388607);
		base_y       = jit(8388607);
		base_z       = jit(8388607);
		valid_pct    = $urandom_range(70, 100);
		noise_pct    = $urandom_range(0, 12);

		if ($urandom_range(0, 1)) begin
			roll = $urandom_range(0, 99);
			if (roll < 3)
				set_reg(REG_ROW_WIDTH, $urandom_range(1024, 2047));
			else if (roll < 8)
				set_reg(REG_ROW_WIDTH, $urandom_range(0, 1));
			else
				set_reg(REG_ROW_WIDTH, $urandom_range(2, 12));
		end
		if ($urandom_range(0, 1)) begin
			roll = $urandom_range(0, 99);
			if (roll < 2)
				set_reg(REG_ROW_COUNT, 2047);
			else if (roll < 4)
				set_reg(REG_ROW_COUNT, $urandom_range(1024, 2046));
			else if (roll < 10)
				set_reg(REG_ROW_COUNT, $urandom_range(0, 1));
			else
				set_reg(REG_ROW_COUNT, $urandom_range(2, 8));
		end
		if ($urandom_range(0, 99) < 70) begin
			roll = $urandom_range(0, 99);
			if (roll < 8)
				set_reg(REG_EDGE_LIMIT, 0);
			else if (roll < 12)
				set_reg(REG_EDGE_LIMIT, 1);
			else if (roll < 18)
				set_reg(REG_EDGE_LIMIT, LIM_MAX);
			else if (roll < 24)
				set_reg(REG_EDGE_LIMIT, $urandom_range(0, LIM_MAX));
			else
				set_reg(REG_EDGE_LIMIT, pitch * $urandom_range(80, 220) / 100);
		end
	endtask

	initial begin
		int budget, n;
		mesh         = new();
		steady       = 1'b0;
		pitch        = 400;
		jitter       = 60;
		depth_jitter = 200;
		base_x       = 0;
		base_y       = 0;
		base_z       = 0;
		valid_pct    = 95;
		noise_pct    = 2;

		// Reset once
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Small frame, widest limit: coordinate extremes and a rejected long edge
		set_reg(REG_ROW_WIDTH, 3);
		set_reg(REG_ROW_COUNT, 2);
		set_reg(REG_EDGE_LIMIT, LIM_MAX);
		send_vertex(vertex_at(0, 0, 0, 1'b1));
		send_vertex(vertex_at(100, 0, 0, 1'b1));
		send_vertex(vertex_at(200, 0, 0, 1'b1));
		send_vertex(vertex_at(0, 100, 0, 1'b1));
		send_vertex(vertex_at(100, 100, 0, 1'b1));
		send_vertex(vertex_at(8388607, -8388608, 8388607, 1'b1));

		// Second frame near the negative corner, with an invalid vertex
		send_vertex(vertex_at(-8388608, -8388608, -8388608, 1'b1));
		send_vertex(vertex_at(-8388508, -8388608, -8388608, 1'b1));
		send_vertex(vertex_at(8388607, 8388607, 8388607, 1'b0));
		send_vertex(vertex_at(-8388608, -8388508, -8388608, 1'b1));
		send_vertex(vertex_at(-8388508, -8388508, -8388500, 1'b1));
		send_vertex(vertex_at(-8388408, -8388508, -8388600, 1'b1));

		// Out-of-range dimensions clamp; every tested edge lies under the limit
		settle();
		set_reg(REG_EDGE_LIMIT, 1000);
		set_reg(REG_ROW_WIDTH, 0);
		set_reg(REG_ROW_COUNT, 2047);
		send_vertex(vertex_at(0, 0, 0, 1'b1));
		send_vertex(vertex_at(500, 0, 0, 1'b1));
		send_vertex(vertex_at(0, 500, 0, 1'b1));
		send_vertex(vertex_at(500, 500, 0, 1'b1));
		send_vertex(vertex_at(0, 1000, 0, 1'b1));
		send_vertex(vertex_at(500, 1000, 0, 1'b1));

		// Lower the row count below the current row: frame ends with this row
		settle();
		set_reg(REG_ROW_COUNT, 1);
		send_vertex(vertex_at(0, 2000, 0, 1'b1));
		send_vertex(vertex_at(500, 1999, 0, 1'b1));

		// Full-width row fills the whole line store, then the width drops mid-row
		settle();
		set_reg(REG_ROW_WIDTH, 2047);
		set_reg(REG_ROW_COUNT, 2);
		set_reg(REG_EDGE_LIMIT, 520);
		repeat (LINE_DEPTH + 40) send_vertex(grid_vertex());
		settle();
		set_reg(REG_ROW_WIDTH, 5);
		send_vertex(grid_vertex());
		send_vertex(grid_vertex());

		// Random phases, each under a fresh setting
		budget = RANDOM_ITEMS;
		while (budget > 0) begin
			new_setting();
			n = $urandom_range(20, 120);
			repeat (n) send_vertex(grid_vertex());
			budget -= n;
		end

		settle();
		repeat (10) @(negedge clk);
		mesh.close_out();
		if (mesh.errors == 0)
			$display("depth_grid_triangulator_unit test passed");
		else
			$display("depth_grid_triangulator_unit test failed");
		$finish;
	end

endmodule
